### rtl/core/particle_arrive_steer_step_assert.svh
// assertion macros used by the checker file
`ifndef PARTICLE_ARRIVE_STEER_STEP_ASSERT_SVH
`define PARTICLE_ARRIVE_STEER_STEP_ASSERT_SVH

// clocked assertion, masked while reset is high
`define PAS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds across reset
`define PAS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/pas_pkg.sv
// types, codes and saturating helpers for the particle step block
`default_nettype none
package pas_pkg;

   localparam int WORD_W = 32;
   localparam int REG_W  = 31;

   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // command codes
   localparam logic [1:0] CMD_SPAWN = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_SEEK  = 2'd2;
   localparam logic [1:0] CMD_HOLD  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_MAX_SPEED = 2'd0;
   localparam logic [1:0] CSR_MAX_FORCE = 2'd1;
   localparam logic [1:0] CSR_DEATH     = 2'd2;
   localparam logic [1:0] CSR_RADIUS    = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DIFF, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT_GO, ST_SQRT_WAIT,
      ST_RAMP_MUL, ST_RAMP_DIV, ST_RAMP_WAIT, ST_WANT, ST_SCL_MUL, ST_SCL_DIV,
      ST_SCL_WAIT, ST_STEER_SUB, ST_FORCE_ADD, ST_VEL_ADD, ST_VEL_PUT, ST_MOVE,
      ST_DONE
   } pas_state_type;

   typedef enum logic [1:0] {
      PH_DIST, PH_STEER, PH_VEL
   } pas_phase_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } pas_div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } pas_div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } pas_sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } pas_sqrt_rsp_type;

   function automatic logic signed [WORD_W-1:0] sat_add(
      input logic signed [WORD_W-1:0] a, input logic signed [WORD_W-1:0] b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? WORD_MIN : WORD_MAX;
      return s[WORD_W-1:0];
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_sub(
      input logic signed [WORD_W-1:0] a, input logic signed [WORD_W-1:0] b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? WORD_MIN : WORD_MAX;
      return s[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] abs_word(input logic signed [WORD_W-1:0] a);
      return a[WORD_W-1] ? (~a + 1'b1) : a;
   endfunction

endpackage
`default_nettype wire

### rtl/core/particle_arrive_steer_step.sv
// particle step block: arrive steering on one 3D particle, Q16.16
// Usage:
//  req channel: one beat is a command (spawn, free tick, seek tick, hold) with a
//  vector, a spawn force and a spawn lifespan; req_stall is high while a command
//  is being worked on.
//  rsp channel: one beat per command with position, velocity, lifespan and dead.
//  csr port: csr_write with csr_index and csr_data sets max speed, max force,
//  death rate and arrive radius; write only while the block is idle.
// Sequencing:
//  spawn and hold go straight to the result step, a free tick adds force to
//  velocity and moves; a seek tick uses the shared bit-serial divider (up to
//  ten quotients) and the square root unit (three roots), all sequenced
//  through one registered multiplier.
//  A new command is taken as soon as the previous result sits in the output
//  register, even while the receiver stalls it.
// Reset: synchronous, active high; the state is cleared to zero, the registers
//  take their defaults and no rsp beat is pending.
// Stall: a stalled rsp beat holds; the next result waits in the last sequencer
//  step until the output register frees.
`default_nettype none
module particle_arrive_steer_step import pas_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_cmd,
   input  wire logic signed [31:0] req_vec_x,
   input  wire logic signed [31:0] req_vec_y,
   input  wire logic signed [31:0] req_vec_z,
   input  wire logic signed [31:0] req_force_x,
   input  wire logic signed [31:0] req_force_y,
   input  wire logic signed [31:0] req_force_z,
   input  wire logic [30:0]        req_life_init,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_pos_z,
   output logic signed [31:0]      rsp_vel_x,
   output logic signed [31:0]      rsp_vel_y,
   output logic signed [31:0]      rsp_vel_z,
   output logic signed [31:0]      rsp_life_left,
   output logic                    rsp_dead,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [30:0]        csr_data
);
   pas_state_type state_ff, state_in;
   pas_phase_type phase_ff, phase_in;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] vel_in [3];
   logic signed [31:0] frc_ff [3];
   logic signed [31:0] frc_in [3];
   logic signed [31:0] vec_ff [3];
   logic signed [31:0] vec_in [3];
   logic signed [31:0] life_ff, life_in;

   logic [1:0]  cmd_ff, cmd_in;
   logic [1:0]  idx_ff, idx_in;
   logic [63:0] sum_ff, sum_in;
   logic [31:0] dist_ff, dist_in;
   logic [31:0] spd_ff, spd_in;
   logic [31:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;

   logic [30:0] max_speed_ff, max_force_ff, death_ff, radius_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_pos_ff [3];
   logic signed [31:0] rsp_vel_ff [3];
   logic signed [31:0] rsp_life_ff;
   logic               rsp_dead_ff;
   logic               load_rsp;
   logic               out_free;

   logic [31:0]      mul_a, mul_b;
   logic [63:0]      prod;
   pas_div_req_type  div_req;
   pas_div_rsp_type  div_rsp;
   pas_sqrt_req_type sqrt_req;
   pas_sqrt_rsp_type sqrt_rsp;

   logic [31:0] cur_abs;
   logic        cur_neg;
   logic [30:0] scl_mag;
   logic [31:0] scl_pos;
   logic signed [31:0] vsum [3];

   // shared arithmetic units
   pas_mul u_mul (.clock(clock), .mul_a(mul_a), .mul_b(mul_b), .prod(prod));
   pas_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));
   pas_sqrt u_sqrt (.clock(clock), .reset(reset), .req(sqrt_req), .rsp(sqrt_rsp));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cur_abs  = abs_word(vec_ff[idx_ff]);
   assign cur_neg  = vec_ff[idx_ff][31];
   assign scl_mag  = (div_rsp.quotient[63:31] != 33'd0) ? {31{1'b1}}
                                                        : div_rsp.quotient[30:0];
   assign scl_pos  = {1'b0, scl_mag};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  CMD_SEEK: state_in = ST_DIFF;
                  CMD_FREE: state_in = ST_VEL_ADD;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_DIFF:     state_in = ST_SQ_MUL;
         ST_SQ_MUL:   state_in = ST_SQ_ACC;
         ST_SQ_ACC:   state_in = (idx_ff == 2'd2) ? ST_SQRT_GO : ST_SQ_MUL;
         ST_SQRT_GO:  state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: begin
            if (sqrt_rsp.done) begin
               case (phase_ff)
                  PH_DIST:  state_in = (sqrt_rsp.root < {1'b0, radius_ff}) ? ST_RAMP_MUL
                                                                          : ST_WANT;
                  PH_STEER: state_in = (sqrt_rsp.root > {1'b0, max_force_ff}) ? ST_SCL_MUL
                                                                             : ST_FORCE_ADD;
                  default:  state_in = (sqrt_rsp.root > {1'b0, max_speed_ff}) ? ST_SCL_MUL
                                                                             : ST_VEL_PUT;
               endcase
            end
         end
         ST_RAMP_MUL:  state_in = ST_RAMP_DIV;
         ST_RAMP_DIV:  state_in = ST_RAMP_WAIT;
         ST_RAMP_WAIT: if (div_rsp.done) state_in = ST_WANT;
         ST_WANT:      state_in = (dist_ff == 32'd0) ? ST_STEER_SUB : ST_SCL_MUL;
         ST_SCL_MUL:   state_in = ST_SCL_DIV;
         ST_SCL_DIV:   state_in = ST_SCL_WAIT;
         ST_SCL_WAIT: begin
            if (div_rsp.done) begin
               if (idx_ff != 2'd2) begin
                  state_in = ST_SCL_MUL;
               end else begin
                  case (phase_ff)
                     PH_DIST:  state_in = ST_STEER_SUB;
                     PH_STEER: state_in = ST_FORCE_ADD;
                     default:  state_in = ST_VEL_PUT;
                  endcase
               end
            end
         end
         ST_STEER_SUB: state_in = ST_SQ_MUL;
         ST_FORCE_ADD: state_in = ST_VEL_ADD;
         ST_VEL_ADD:   state_in = (cmd_ff == CMD_SEEK) ? ST_SQ_MUL : ST_MOVE;
         ST_VEL_PUT:   state_in = ST_MOVE;
         ST_MOVE:      state_in = ST_DONE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // unit operands and handshake outputs
   always_comb begin
      mul_a             = 32'd0;
      mul_b             = 32'd0;
      div_req.start     = 1'b0;
      div_req.dividend  = prod;
      div_req.divisor   = den_ff;
      sqrt_req.start    = 1'b0;
      sqrt_req.radicand = sum_ff;
      req_stall         = (state_ff != ST_IDLE);
      load_rsp          = 1'b0;
      case (state_ff)
         ST_SQ_MUL: begin
            mul_a = cur_abs;
            mul_b = cur_abs;
         end
         ST_RAMP_MUL: begin
            mul_a = {1'b0, max_speed_ff};
            mul_b = dist_ff;
         end
         ST_SCL_MUL: begin
            mul_a = cur_abs;
            mul_b = num_ff;
         end
         ST_RAMP_DIV: begin
            div_req.start   = 1'b1;
            div_req.divisor = {1'b0, radius_ff};
         end
         ST_SCL_DIV:  div_req.start  = 1'b1;
         ST_SQRT_GO:  sqrt_req.start = 1'b1;
         ST_DONE:     load_rsp       = out_free;
         default:     mul_a          = 32'd0;
      endcase
   end

   // particle state and scratch registers
   always_comb begin
      phase_in = phase_ff;
      life_in  = life_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      dist_in  = dist_ff;
      spd_in   = spd_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      for (int i = 0; i < 3; i++) begin
         pos_in[i] = pos_ff[i];
         vel_in[i] = vel_ff[i];
         frc_in[i] = frc_ff[i];
         vec_in[i] = vec_ff[i];
         vsum[i]   = sat_add(vel_ff[i], frc_ff[i]);
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               vec_in[0] = req_vec_x;
               vec_in[1] = req_vec_y;
               vec_in[2] = req_vec_z;
               if (req_cmd == CMD_SPAWN) begin
                  pos_in[0] = req_vec_x;
                  pos_in[1] = req_vec_y;
                  pos_in[2] = req_vec_z;
                  frc_in[0] = req_force_x;
                  frc_in[1] = req_force_y;
                  frc_in[2] = req_force_z;
                  for (int i = 0; i < 3; i++) vel_in[i] = 32'sd0;
                  life_in = {1'b0, req_life_init};
               end
            end
         end
         ST_DIFF: begin
            for (int i = 0; i < 3; i++) vec_in[i] = sat_sub(vec_ff[i], pos_ff[i]);
            phase_in = PH_DIST;
            idx_in   = 2'd0;
            sum_in   = 64'd0;
         end
         ST_SQ_ACC: begin
            sum_in = sum_ff + prod;
            idx_in = idx_ff + 2'd1;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_rsp.done) begin
               idx_in = 2'd0;
               case (phase_ff)
                  PH_DIST: begin
                     dist_in = sqrt_rsp.root;
                     spd_in  = {1'b0, max_speed_ff};
                  end
                  PH_STEER: begin
                     num_in = {1'b0, max_force_ff};
                     den_in = sqrt_rsp.root;
                  end
                  default: begin
                     num_in = {1'b0, max_speed_ff};
                     den_in = sqrt_rsp.root;
                  end
               endcase
            end
         end
         ST_RAMP_WAIT: if (div_rsp.done) spd_in = div_rsp.quotient[31:0];
         ST_WANT: begin
            num_in = spd_ff;
            den_in = dist_ff;
            idx_in = 2'd0;
            if (dist_ff == 32'd0) begin
               for (int i = 0; i < 3; i++) vec_in[i] = 32'sd0;
            end
         end
         ST_SCL_WAIT: begin
            if (div_rsp.done) begin
               vec_in[idx_ff] = cur_neg ? (~scl_pos + 32'd1) : scl_pos;
               idx_in         = idx_ff + 2'd1;
            end
         end
         ST_STEER_SUB: begin
            for (int i = 0; i < 3; i++) vec_in[i] = sat_sub(vec_ff[i], vel_ff[i]);
            phase_in = PH_STEER;
            idx_in   = 2'd0;
            sum_in   = 64'd0;
         end
         ST_FORCE_ADD: begin
            for (int i = 0; i < 3; i++) frc_in[i] = sat_add(frc_ff[i], vec_ff[i]);
         end
         ST_VEL_ADD: begin
            for (int i = 0; i < 3; i++) begin
               vel_in[i] = vsum[i];
               vec_in[i] = vsum[i];
            end
            phase_in = PH_VEL;
            idx_in   = 2'd0;
            sum_in   = 64'd0;
         end
         ST_VEL_PUT: begin
            for (int i = 0; i < 3; i++) vel_in[i] = vec_ff[i];
         end
         ST_MOVE: begin
            for (int i = 0; i < 3; i++) begin
               pos_in[i] = sat_add(pos_ff[i], vel_ff[i]);
               if (cmd_ff == CMD_SEEK) frc_in[i] = 32'sd0;
            end
            life_in = sat_sub(life_ff, {1'b0, death_ff});
         end
         default: idx_in = idx_ff;
      endcase
   end

   // output beat register
   always_comb begin
      if (load_rsp) rsp_valid_in = 1'b1;
      else          rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_DIST;
         rsp_valid_ff <= 1'b0;
         life_ff      <= 32'sd0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= 32'sd0;
            vel_ff[i] <= 32'sd0;
            frc_ff[i] <= 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         life_ff      <= life_in;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= pos_in[i];
            vel_ff[i] <= vel_in[i];
            frc_ff[i] <= frc_in[i];
         end
      end
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      dist_ff <= dist_in;
      spd_ff  <= spd_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      for (int i = 0; i < 3; i++) vec_ff[i] <= vec_in[i];
      if (load_rsp) begin
         for (int i = 0; i < 3; i++) begin
            rsp_pos_ff[i] <= pos_ff[i];
            rsp_vel_ff[i] <= vel_ff[i];
         end
         rsp_life_ff <= life_ff;
         rsp_dead_ff <= life_ff[31] || (life_ff == 32'sd0);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= 31'd65536;
         max_force_ff <= 31'd6554;
         death_ff     <= 31'd65536;
         radius_ff    <= 31'd655360;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAX_SPEED: max_speed_ff <= csr_data;
            CSR_MAX_FORCE: max_force_ff <= csr_data;
            CSR_DEATH:     death_ff     <= csr_data;
            CSR_RADIUS:    radius_ff    <= csr_data;
            default:       radius_ff    <= radius_ff;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = rsp_pos_ff[0];
   assign rsp_pos_y     = rsp_pos_ff[1];
   assign rsp_pos_z     = rsp_pos_ff[2];
   assign rsp_vel_x     = rsp_vel_ff[0];
   assign rsp_vel_y     = rsp_vel_ff[1];
   assign rsp_vel_z     = rsp_vel_ff[2];
   assign rsp_life_left = rsp_life_ff;
   assign rsp_dead      = rsp_dead_ff;
endmodule
`default_nettype wire

### rtl/core/pas_mul.sv
// registered 32 by 32 unsigned multiplier
`default_nettype none
module pas_mul import pas_pkg::*; (
   input  wire logic        clock,
   input  wire logic [31:0] mul_a,
   input  wire logic [31:0] mul_b,
   output logic      [63:0] prod
);
   logic [63:0] prod_ff;

   // product ready in the cycle after the operands
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

### rtl/core/pas_div.sv
// restoring divider, 64 by 32 bits, one quotient bit per cycle
`default_nettype none
module pas_div import pas_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire pas_div_req_type req,
   output pas_div_rsp_type      rsp
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   // one shift and trial subtract per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, dvd_ff[63]};
      diff    = shifted - {1'b0, dsr_ff};
      if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            dvd_in = {dvd_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            dvd_in = {dvd_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         dvd_in  = req.dividend;
         rem_in  = 32'd0;
         dsr_in  = req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff;
endmodule
`default_nettype wire

### rtl/core/pas_sqrt.sv
// digit-by-digit integer square root, 64-bit radicand, one root bit per cycle
`default_nettype none
module pas_sqrt import pas_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pas_sqrt_req_type req,
   output pas_sqrt_rsp_type      rsp
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [34:0] cur;
   logic [34:0] trial;
   logic [34:0] diff;

   // bring down two radicand bits, try root*4+1
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cur     = {rem_ff[32:0], rad_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = cur - trial;
      if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (!diff[34]) begin
            rem_in  = diff[33:0];
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = cur[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         rad_in  = req.radicand;
         rem_in  = 34'd0;
         root_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;
endmodule
`default_nettype wire

### rtl/core/pas_check.sv
// port-level checker for the particle step block, bound to the top level
`default_nettype none
`include "particle_arrive_steer_step_assert.svh"
module pas_check import pas_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_pos_x,
   input wire logic signed [31:0] rsp_life_left,
   input wire logic               rsp_dead
);
   // no result beat right after reset
   `PAS_ASSERT_RST(a_rst_quiet, reset |=> !rsp_valid, "rsp_valid after reset")

   // an accepted command keeps the input stalled while it is worked on
   `PAS_ASSERT(a_busy, (req_valid && !req_stall) |=> req_stall, "second beat taken")

   // a stalled result beat holds
   `PAS_ASSERT(a_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pos_x) && $stable(rsp_life_left)), "stalled beat changed")

   // dead flag follows the reported lifespan
   `PAS_ASSERT(a_dead, rsp_valid |-> (rsp_dead == (rsp_life_left[31] || (rsp_life_left == 32'sd0))), "dead flag wrong")
endmodule

bind particle_arrive_steer_step pas_check u_pas_check (.*);
`default_nettype wire

### dv/particle_arrive_steer_step_tb.sv
// testbench for the particle step block: directed and random beats checked against a built-in predictor
`timescale 1ns / 100ps
`default_nettype none
module particle_arrive_steer_step_tb;
   import pas_pkg::*;

   localparam int  WATCHDOG_LIMIT = 20000;
   localparam longint WMAXL = 64'sd2147483647;
   localparam longint WMINL = -64'sd2147483648;

   typedef longint vec3_type [3];

   typedef struct {
      logic [1:0]         cmd;
      logic signed [31:0] vec [3];
      logic signed [31:0] frc [3];
      logic [30:0]        life;
   } step_cmd_type;

   typedef struct {
      logic signed [31:0] pos [3];
      logic signed [31:0] vel [3];
      logic signed [31:0] life;
      logic               dead;
   } step_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic signed [31:0] rsp_life_left;
   logic rsp_dead;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_MAX_SPEED;
   logic [30:0] csr_data = '0;

   step_cmd_type cur_cmd = '{cmd: CMD_HOLD, vec: '{0, 0, 0}, frc: '{0, 0, 0}, life: '0};
   step_cmd_type cmd_q [$];
   step_out_type out_q [$];

   // particle state and register shadow
   longint p_pos [3], p_vel [3], p_frc [3];
   longint p_life;
   longint unsigned r_speed, r_force, r_death, r_radius;

   int errors = 0;
   int n_spawn = 0, n_free = 0, n_seek = 0, n_hold = 0, n_dead = 0, n_beats = 0;
   int idle_cycles = 0;
   int burst_left = 1, gap_left = 0;
   bit steady_send = 0;
   int stall_mode = 0, stall_run = 0, mode_timer = 0;

   always #4 clock = ~clock;

   particle_arrive_steer_step dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(cur_cmd.cmd),
      .req_vec_x(cur_cmd.vec[0]), .req_vec_y(cur_cmd.vec[1]), .req_vec_z(cur_cmd.vec[2]),
      .req_force_x(cur_cmd.frc[0]), .req_force_y(cur_cmd.frc[1]),
      .req_force_z(cur_cmd.frc[2]), .req_life_init(cur_cmd.life),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_vel_x(rsp_vel_x), .rsp_vel_y(rsp_vel_y), .rsp_vel_z(rsp_vel_z),
      .rsp_life_left(rsp_life_left), .rsp_dead(rsp_dead),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // fixed point helpers
   function automatic longint sat_w(longint v);
      if (v > WMAXL) return WMAXL;
      if (v < WMINL) return WMINL;
      return v;
   endfunction

   function automatic longint unsigned mag_abs(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned vec_len(vec3_type v);
      longint unsigned a [3];
      longint unsigned mx, sum, t;
      int s;
      mx = 0;
      sum = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = mag_abs(v[i]);
         if (a[i] > mx) mx = a[i];
      end
      while ((mx >> s) > (64'h1 << 31)) s++;
      for (int i = 0; i < 3; i++) begin
         t = a[i] >> s;
         sum += t * t;
      end
      return int_sqrt(sum) << s;
   endfunction

   // floor(a*b/c) with a wide product, clipped to the word maximum
   function automatic longint unsigned mul_div(longint unsigned a, longint unsigned b,
                                               longint unsigned c);
      logic [127:0] prod;
      logic [127:0] q;
      prod = {64'd0, a} * {64'd0, b};
      q = prod / {64'd0, c};
      return q > 128'(WMAXL) ? longint'(WMAXL) : q[63:0];
   endfunction

   function automatic longint scale_comp(longint v, longint unsigned num,
                                         longint unsigned den);
      longint m;
      m = longint'(mul_div(mag_abs(v), num, den));
      return v < 0 ? -m : m;
   endfunction

   function automatic vec3_type clamp_len(vec3_type v, longint unsigned lim);
      longint unsigned m;
      vec3_type r;
      m = vec_len(v);
      r = v;
      if (m > lim) for (int i = 0; i < 3; i++) r[i] = scale_comp(v[i], lim, m);
      return r;
   endfunction

   // advance the particle by one command and queue the expected beat
   task automatic advance_particle(step_cmd_type c);
      vec3_type d, st, v;
      longint unsigned seek_len, spd;
      longint want;
      step_out_type o;
      case (c.cmd)
         CMD_SPAWN: begin
            for (int i = 0; i < 3; i++) begin
               p_pos[i] = c.vec[i];
               p_frc[i] = c.frc[i];
               p_vel[i] = 0;
            end
            p_life = c.life;
            n_spawn++;
         end
         CMD_FREE, CMD_SEEK: begin
            if (c.cmd == CMD_SEEK) begin
               for (int i = 0; i < 3; i++) d[i] = sat_w(longint'(c.vec[i]) - p_pos[i]);
               seek_len = vec_len(d);
               spd = r_speed;
               if (seek_len < r_radius) spd = mul_div(r_speed, seek_len, r_radius);
               for (int i = 0; i < 3; i++) begin
                  want = seek_len != 0 ? scale_comp(d[i], spd, seek_len) : 0;
                  st[i] = sat_w(want - p_vel[i]);
               end
               st = clamp_len(st, r_force);
               for (int i = 0; i < 3; i++) p_frc[i] = sat_w(p_frc[i] + st[i]);
               n_seek++;
            end else n_free++;
            for (int i = 0; i < 3; i++) v[i] = sat_w(p_vel[i] + p_frc[i]);
            if (c.cmd == CMD_SEEK) v = clamp_len(v, r_speed);
            for (int i = 0; i < 3; i++) begin
               p_vel[i] = v[i];
               p_pos[i] = sat_w(p_pos[i] + p_vel[i]);
               if (c.cmd == CMD_SEEK) p_frc[i] = 0;
            end
            p_life = sat_w(p_life - longint'(r_death));
         end
         default: n_hold++;
      endcase
      for (int i = 0; i < 3; i++) begin
         o.pos[i] = p_pos[i][31:0];
         o.vel[i] = p_vel[i][31:0];
      end
      o.life = p_life[31:0];
      o.dead = p_life <= 0;
      if (o.dead) n_dead++;
      out_q.push_back(o);
   endtask

   // request driver: bursts of beats with random gaps
   always @(posedge clock) begin
      step_cmd_type nxt;
      logic nv;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) advance_particle(cur_cmd);
         if (!req_valid || !req_stall) begin
            nv = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_q.size() > 0) begin
               nxt = cmd_q.pop_front();
               cur_cmd <= nxt;
               nv = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  steady_send = ($urandom_range(0, 3) == 0);
                  gap_left = steady_send ? 0 : $urandom_range(0, 6);
               end
            end
            req_valid <= nv;
         end
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // response monitor and receiver stall pattern
   always @(posedge clock) begin
      step_out_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_beats++;
            if (out_q.size() == 0) begin
               $error("result beat with nothing outstanding");
               errors++;
            end else begin
               e = out_q.pop_front();
               check_field("pos_x", e.pos[0], rsp_pos_x);
               check_field("pos_y", e.pos[1], rsp_pos_y);
               check_field("pos_z", e.pos[2], rsp_pos_z);
               check_field("vel_x", e.vel[0], rsp_vel_x);
               check_field("vel_y", e.vel[1], rsp_vel_y);
               check_field("vel_z", e.vel[2], rsp_vel_z);
               check_field("life_left", e.life, rsp_life_left);
               check_field("dead", 32'(e.dead), 32'(rsp_dead));
            end
         end
         if (mode_timer == 0) begin
            mode_timer = $urandom_range(50, 300);
            stall_mode = $urandom_range(0, 2);
         end else mode_timer--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
               if (stall_run == 0) stall_run = $urandom_range(1, 30);
               stall_run--;
               if (stall_run == 0) rsp_stall <= ~rsp_stall;
            end
         endcase
      end
   end

   // watchdog on stalled progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (out_q.size() == 0 && cmd_q.size() == 0 && !req_valid)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", out_q.size());
            $display("particle_arrive_steer_step regression: fail");
            $finish;
         end
      end
   end

   function automatic step_cmd_type make_cmd(logic [1:0] c, longint x, longint y,
                                             longint z, longint fx, longint fy,
                                             longint fz, logic [30:0] life);
      step_cmd_type s;
      s.cmd = c;
      s.vec = '{x[31:0], y[31:0], z[31:0]};
      s.frc = '{fx[31:0], fy[31:0], fz[31:0]};
      s.life = life;
      return s;
   endfunction

   // coordinate: mostly small values near the arrive radius, sometimes full range
   function automatic longint rand_coord();
      case ($urandom_range(0, 9))
         0: return longint'($signed($urandom()));
         1: return $urandom_range(0, 1) ? WMAXL : WMINL;
         default: return longint'($urandom_range(0, 2097152)) - 1048576;
      endcase
   endfunction

   function automatic logic [30:0] rand_life();
      return $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 1000000));
   endfunction

   function automatic step_cmd_type rand_cmd(logic [1:0] c);
      return make_cmd(c, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord() >>> $urandom_range(0, 12),
                      rand_coord() >>> $urandom_range(0, 12),
                      rand_coord() >>> $urandom_range(0, 12), rand_life());
   endfunction

   // random traffic: mostly a spawn then a run of ticks, some noise
   task automatic add_random(int count);
      int added;
      int run;
      added = 0;
      while (added < count) begin
         if ($urandom_range(0, 9) < 8) begin
            cmd_q.push_back(rand_cmd(CMD_SPAWN));
            run = $urandom_range(2, 10);
            added += run + 1;
            repeat (run)
               cmd_q.push_back(rand_cmd($urandom_range(0, 4) == 0 ? CMD_FREE : CMD_SEEK));
         end else begin
            cmd_q.push_back(rand_cmd(2'($urandom_range(0, 3))));
            added++;
         end
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic [30:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_MAX_SPEED: r_speed = val;
         CSR_MAX_FORCE: r_force = val;
         CSR_DEATH:     r_death = val;
         default:       r_radius = val;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      wait (cmd_q.size() == 0 && !req_valid && out_q.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < 3; i++) begin
         p_pos[i] = 0;
         p_vel[i] = 0;
         p_frc[i] = 0;
      end
      p_life = 0;
      r_speed = 65536;
      r_force = 6554;
      r_death = 65536;
      r_radius = 655360;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, zero distance, inside and outside the radius
      cmd_q.push_back(make_cmd(CMD_HOLD, 0, 0, 0, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_SEEK, 0, 0, 0, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_SPAWN, WMAXL, WMAXL, WMAXL, WMAXL, WMAXL, WMAXL,
                               31'h7fffffff));
      cmd_q.push_back(make_cmd(CMD_FREE, 0, 0, 0, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_SEEK, WMINL, WMINL, WMINL, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_SPAWN, WMINL, WMINL, WMINL, WMINL, WMINL, WMINL, 0));
      cmd_q.push_back(make_cmd(CMD_FREE, -1, -1, -1, -1, -1, -1, 31'h7fffffff));
      cmd_q.push_back(make_cmd(CMD_SEEK, WMAXL, WMAXL, WMAXL, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_SPAWN, 65536, -65536, 0, 0, 0, 0, 31'(3 * 65536)));
      cmd_q.push_back(make_cmd(CMD_SEEK, 65536, -65536, 0, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_SEEK, 4 * 65536, 0, 0, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_SEEK, 100 * 65536, 50 * 65536, -70 * 65536, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_HOLD, 1, 2, 3, 4, 5, 6, 7));
      cmd_q.push_back(make_cmd(CMD_FREE, 0, 0, 0, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_SPAWN, 0, 0, 0, 1000, -2000, 3000, 1));
      cmd_q.push_back(make_cmd(CMD_FREE, 0, 0, 0, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_SEEK, 9 * 65536, 0, 0, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(CMD_SEEK, 10 * 65536, 0, 0, 0, 0, 0, 0));
      add_random(150);
      drain();

      // upper extremes, no aging
      write_reg(CSR_MAX_SPEED, 31'h7fffffff);
      write_reg(CSR_MAX_FORCE, 31'h7fffffff);
      write_reg(CSR_DEATH, 31'd0);
      write_reg(CSR_RADIUS, 31'h7fffffff);
      add_random(100);
      drain();

      // lower extremes, fastest aging
      write_reg(CSR_MAX_SPEED, 31'd0);
      write_reg(CSR_MAX_FORCE, 31'd0);
      write_reg(CSR_DEATH, 31'h7fffffff);
      write_reg(CSR_RADIUS, 31'd1);
      add_random(80);
      drain();

      // random moderate settings
      write_reg(CSR_MAX_SPEED, 31'($urandom_range(1, 8 * 65536)));
      write_reg(CSR_MAX_FORCE, 31'($urandom_range(1, 65536)));
      write_reg(CSR_DEATH, 31'($urandom_range(0, 4 * 65536)));
      write_reg(CSR_RADIUS, 31'($urandom_range(1, 40 * 65536)));
      add_random(120);
      drain();

      $display("covered %0d spawns, %0d free ticks, %0d seek ticks, %0d holds", n_spawn,
               n_free, n_seek, n_hold);
      $display("%0d result beats checked, %0d reported dead, 4 register settings", n_beats,
               n_dead);
      if (errors == 0) $display("particle_arrive_steer_step regression: pass");
      else $display("particle_arrive_steer_step regression: fail");
      $finish;
   end

endmodule
`default_nettype wire

### particle_arrive_steer_step.f
+incdir+rtl/core
rtl/core/pas_pkg.sv
rtl/core/pas_mul.sv
rtl/core/pas_div.sv
rtl/core/pas_sqrt.sv
rtl/core/particle_arrive_steer_step.sv
rtl/core/pas_check.sv
dv/particle_arrive_steer_step_tb.sv
